[src/wsjs_pkg.sv]
// Shared types and constants of the work-stealing job scheduler.
package wsjs_pkg;

    localparam int RingDepth = 64;
    localparam int MaxQueues = 8;
    localparam int JobBits   = 16;

    localparam int SlotW  = $clog2(RingDepth);
    localparam int PtrW   = SlotW + 1;
    localparam int QW     = $clog2(MaxQueues);
    localparam int AddrW  = QW + SlotW;
    localparam int CountW = $clog2(RingDepth + 1);
    localparam int ActW   = 4;

    typedef enum logic [1:0] {
        FUNC_PUSH_NEXT  = 2'd0,
        FUNC_PUSH_BATCH = 2'd1,
        FUNC_FLUSH      = 2'd2,
        FUNC_REQUEST    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_OWN   = 2'd1,
        SRC_STEAL = 2'd2
    } t_source;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         worker;
        logic [JobBits-1:0] job;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [JobBits-1:0] job_out;
        logic [1:0]         source;
        logic               overflow;
        logic [CountW-1:0]  moved;
    } t_result;

endpackage

[src/wsjs_if.sv]
// Valid/ready channel interfaces for commands and results.
interface wsjs_cmd_if;
    logic            valid;
    logic            ready;
    wsjs_pkg::t_cmd  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wsjs_res_if;
    logic              valid;
    logic              ready;
    wsjs_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/work_stealing_job_scheduler.sv]
// Top level of the work-stealing job scheduler.
// Usage:
//   i_cmd carries one request per accepted transfer: func, worker, job.
//   o_res returns exactly one result per request, in request order.
//   i_cfg_we/i_cfg_data write active_queues; the user must write it only while
//   the block is idle, as the block itself does not enforce this.
//   A flush pops each job of the worker's batch ring (up to 64) and pushes
//   it to the next run queue in round-robin order unless that queue is full.
//   The sequencer handles one request at a time; a two-entry queue in front
//   keeps accepting while the sequencer works.
// Reset:
//   Synchronous, active low. All ring pointers and round-robin counters
//   clear and active_queues returns to 8. Ring memories are not cleared;
//   only written entries ever reach a result.
// Stall:
//   A result waits in the output register until taken; the sequencer waits
//   behind it and the front queue fills, then i_cmd.ready drops.
module work_stealing_job_scheduler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wsjs_pkg::ActW-1:0] i_cfg_data,
    wsjs_cmd_if.sink                  i_cmd,
    wsjs_res_if.source                o_res
);
    logic           w_valid;
    logic           w_take;
    wsjs_pkg::t_cmd w_cmd;

    wsjs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (w_valid),
        .o_cmd   (w_cmd),
        .i_take  (w_take)
    );

    wsjs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_valid),
        .i_cmd      (w_cmd),
        .o_take     (w_take),
        .o_res      (o_res)
    );
endmodule

[src/wsjs_front.sv]
// Command front end: accepts requests and holds them in a two-entry queue.
module wsjs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wsjs_cmd_if.sink       i_cmd,
    output logic           o_valid,
    output wsjs_pkg::t_cmd o_cmd,
    input  logic           i_take
);
    wsjs_pkg::t_cmd r_q [2];
    logic           r_rd;
    logic           r_wr;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign w_push = i_cmd.valid && i_cmd.ready;
    assign w_pop  = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_cmd.payload;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[src/wsjs_back.sv]
// Command back end: pointer tables, ring memories and the command sequencer.
module wsjs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wsjs_pkg::ActW-1:0] i_cfg_data,
    input  logic                      i_valid,
    input  wsjs_pkg::t_cmd            i_cmd,
    output logic                      o_take,
    wsjs_res_if.source                o_res
);
    localparam int QW    = wsjs_pkg::QW;
    localparam int PtrW  = wsjs_pkg::PtrW;
    localparam int SlotW = wsjs_pkg::SlotW;
    localparam int AddrW = wsjs_pkg::AddrW;
    localparam int JB    = wsjs_pkg::JobBits;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FLUSH = 5'b00010,
        ST_FMOVE = 5'b00100,
        ST_READ  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    // Remainder of a round-robin counter by the active count, by shifted
    // compare and subtract.
    function automatic logic [QW-1:0] rr_mod(logic [QW-1:0] ctr, logic [QW:0] act);
        logic [2*QW:0] rem;
        logic [2*QW:0] dv;
        rem = (2*QW+1)'(ctr);
        for (int s = QW - 1; s >= 0; s--) begin
            dv = (2*QW+1)'(act) << s;
            if (rem >= dv) rem = rem - dv;
        end
        return rem[QW-1:0];
    endfunction

    t_state r_state;
    logic [JB-1:0] r_run_mem   [wsjs_pkg::MaxQueues*wsjs_pkg::RingDepth];
    logic [JB-1:0] r_batch_mem [wsjs_pkg::MaxQueues*wsjs_pkg::RingDepth];
    logic [PtrW-1:0] r_rf [wsjs_pkg::MaxQueues];
    logic [PtrW-1:0] r_rb [wsjs_pkg::MaxQueues];
    logic [PtrW-1:0] r_bf [wsjs_pkg::MaxQueues];
    logic [PtrW-1:0] r_bb [wsjs_pkg::MaxQueues];
    logic [QW-1:0]   r_next;
    logic [QW-1:0]   r_steal;
    logic [wsjs_pkg::ActW-1:0] r_active;
    logic [JB-1:0]   r_run_rd;
    logic [JB-1:0]   r_batch_rd;
    logic [QW-1:0]   r_w;
    logic            r_overflow;
    logic [wsjs_pkg::CountW-1:0] r_moved;
    logic            r_found;
    logic [1:0]      r_source;
    wsjs_pkg::t_result r_res;
    logic            r_res_valid;

    logic [QW:0]     w_act;
    logic [QW-1:0]   w_nsel, w_nnext, w_ssel, w_snext;
    logic [QW-1:0]   w_w;
    logic            w_go;
    logic [PtrW-1:0] w_cnt_rw, w_cnt_bw, w_cnt_rn, w_cnt_rs, w_cnt_rq;
    logic [PtrW-1:0] w_bbm1, w_rbm1;
    logic [QW-1:0]   w_fq;

    // Active count saturated to 1..MaxQueues.
    always_comb begin
        if (r_active == '0) w_act = (QW+1)'(1);
        else if (32'(r_active) > wsjs_pkg::MaxQueues) w_act = (QW+1)'(wsjs_pkg::MaxQueues);
        else w_act = (QW+1)'(r_active);
    end

    always_comb begin
        w_nsel = rr_mod(r_next, w_act);
        w_nnext = ({1'b0, w_nsel} + 1'b1 == w_act) ? '0 : w_nsel + 1'b1;
        w_ssel = rr_mod(r_steal, w_act);
        w_snext = ({1'b0, w_ssel} + 1'b1 == w_act) ? '0 : w_ssel + 1'b1;
    end

    assign w_w = i_cmd.worker[QW-1:0];
    assign w_cnt_rw = r_rb[w_w] - r_rf[w_w];
    assign w_cnt_bw = r_bb[r_w] - r_bf[r_w];
    assign w_cnt_rn = r_rb[w_nsel] - r_rf[w_nsel];
    assign w_cnt_rs = r_rb[w_ssel] - r_rf[w_ssel];
    assign w_cnt_rq = w_cnt_bw;
    assign w_bbm1 = r_bb[r_w] - 1'b1;
    assign w_rbm1 = r_rb[w_w] - 1'b1;
    assign w_fq = w_nsel;

    wire w_res_free = !r_res_valid || o_res.ready;
    assign w_go = (r_state == ST_IDLE) && i_valid && w_res_free;
    assign o_take = w_go;
    assign o_res.valid = r_res_valid;
    assign o_res.payload = r_res;

    // The modulo queue count of the pointers: count of depth means full.
    wire w_run_full_n  = w_cnt_rn[PtrW-1];

    always_ff @(posedge i_clk) begin
        // Ring memories, written and read in this block.
        if (w_go && i_cmd.func == wsjs_pkg::FUNC_PUSH_NEXT && !w_run_full_n) begin
            r_run_mem[{w_nsel, r_rb[w_nsel][SlotW-1:0]}] <= i_cmd.job;
        end
        if (w_go && i_cmd.func == wsjs_pkg::FUNC_PUSH_BATCH
            && !(r_bb[w_w] - r_bf[w_w] == PtrW'(wsjs_pkg::RingDepth))) begin
            r_batch_mem[{w_w, r_bb[w_w][SlotW-1:0]}] <= i_cmd.job;
        end
        if (r_state == ST_FLUSH && w_cnt_rq != '0) begin
            r_batch_rd <= r_batch_mem[{r_w, w_bbm1[SlotW-1:0]}];
        end
        if (r_state == ST_FMOVE && !w_run_full_n) begin
            r_run_mem[{w_fq, r_rb[w_fq][SlotW-1:0]}] <= r_batch_rd;
        end
        if (w_go && i_cmd.func == wsjs_pkg::FUNC_REQUEST) begin
            if (w_cnt_rw != '0) r_run_rd <= r_run_mem[{w_w, w_rbm1[SlotW-1:0]}];
            else                r_run_rd <= r_run_mem[{w_ssel, r_rf[w_ssel][SlotW-1:0]}];
        end

        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next      <= '0;
            r_steal     <= '0;
            r_active    <= wsjs_pkg::ActW'(wsjs_pkg::MaxQueues);
            r_res_valid <= 1'b0;
            for (int i = 0; i < wsjs_pkg::MaxQueues; i++) begin
                r_rf[i] <= '0; r_rb[i] <= '0; r_bf[i] <= '0; r_bb[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_active <= i_cfg_data;
            if (r_state == ST_OUT && w_res_free) r_res_valid <= 1'b1;
            else if (o_res.ready) r_res_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_go) begin
                        r_w        <= w_w;
                        r_overflow <= 1'b0;
                        r_moved    <= '0;
                        r_found    <= 1'b0;
                        r_source   <= wsjs_pkg::SRC_NONE;
                        unique case (wsjs_pkg::t_func'(i_cmd.func))
                            wsjs_pkg::FUNC_PUSH_NEXT: begin
                                r_next <= w_nnext;
                                if (w_run_full_n) r_overflow <= 1'b1;
                                else r_rb[w_nsel] <= r_rb[w_nsel] + 1'b1;
                                r_state <= ST_OUT;
                            end
                            wsjs_pkg::FUNC_PUSH_BATCH: begin
                                if (r_bb[w_w] - r_bf[w_w] == PtrW'(wsjs_pkg::RingDepth))
                                    r_overflow <= 1'b1;
                                else r_bb[w_w] <= r_bb[w_w] + 1'b1;
                                r_state <= ST_OUT;
                            end
                            wsjs_pkg::FUNC_FLUSH: r_state <= ST_FLUSH;
                            wsjs_pkg::FUNC_REQUEST: begin
                                if (w_cnt_rw != '0) begin
                                    if (w_cnt_rw == PtrW'(1)) r_rf[w_w] <= r_rf[w_w] + 1'b1;
                                    else r_rb[w_w] <= w_rbm1;
                                    r_found  <= 1'b1;
                                    r_source <= wsjs_pkg::SRC_OWN;
                                end else begin
                                    r_steal <= w_snext;
                                    if (w_ssel != w_w && w_cnt_rs != '0) begin
                                        r_rf[w_ssel] <= r_rf[w_ssel] + 1'b1;
                                        r_found  <= 1'b1;
                                        r_source <= wsjs_pkg::SRC_STEAL;
                                    end
                                end
                                r_state <= ST_READ;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_FLUSH: begin
                    // Pop the batch back into a register; the next cycle moves it.
                    if (w_cnt_rq == '0) begin
                        r_state <= ST_OUT;
                    end else begin
                        if (w_cnt_rq == PtrW'(1)) r_bf[r_w] <= r_bf[r_w] + 1'b1;
                        else r_bb[r_w] <= w_bbm1;
                        r_state <= ST_FMOVE;
                    end
                end
                ST_FMOVE: begin
                    r_next <= w_nnext;
                    if (w_run_full_n) r_overflow <= 1'b1;
                    else begin
                        r_rb[w_fq] <= r_rb[w_fq] + 1'b1;
                        r_moved <= r_moved + 1'b1;
                    end
                    r_state <= ST_FLUSH;
                end
                ST_READ: r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_res_free) begin
                        r_res.found    <= r_found;
                        r_res.job_out  <= r_found ? r_run_rd : '0;
                        r_res.source   <= r_source;
                        r_res.overflow <= r_overflow;
                        r_res.moved    <= r_moved;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

[src/wsjs_checker.sv]
// Port-level checks of the scheduler and their binding.
module wsjs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              cmd_ready,
    input logic              res_valid,
    input logic              res_ready,
    input wsjs_pkg::t_result res
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");
    a_src_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.found == (res.source != wsjs_pkg::SRC_NONE)))
        else $error("found and source disagree");
    a_job_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res.found |-> res.job_out == '0)
        else $error("job_out nonzero without a job");
    a_moved_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> 32'(res.moved) <= wsjs_pkg::RingDepth)
        else $error("moved beyond ring depth");
    // The front queue is empty right after a reset cycle.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> cmd_ready)
        else $error("not ready after reset");
endmodule

bind work_stealing_job_scheduler wsjs_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .cmd_ready (i_cmd.ready),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .res       (o_res.payload)
);
